>>> hw/rtl/pss_pkg.sv
package pss_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_GET        = 3'd6,
    CMD_SET        = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // per-cell action, broadcast along the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    status_t  status;
    cell_op_t op;
    logic     rd;
    logic     grow;
    logic     shrink;
  } dec_t;

endpackage

>>> hw/rtl/positional_sequence_store.sv
// Positional sequence store: an ordered list of up to CAPACITY words held in
// a chain of cells, element 0 in cell 0 (front).
//
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. cmd picks push/pop at either end, insert, remove, get or set;
// position is signed, a negative value counts back from the current length.
//
// Result channel: done is high for exactly one cycle with data_out, status
// and length valid. There is no back-pressure; the receiver must take it.
//
// Timing: busy is high in the exec state entered on acceptance, in which the
// command is decoded and every cell shifts, loads or holds in parallel.
// done follows on the next cycle. A new transaction may be accepted in the
// same cycle that done is shown, but none is taken while busy is high. The
// read word comes from an OR across the selected cell outputs, which sets
// the exec-cycle path length.
//
// Reset: rst (synchronous) empties the store (internal count 0) and clears done.
// Cell contents are not reset; only cells below length are ever read.
module positional_sequence_store #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    cmd,
  input  logic signed [7:0]             position,
  input  logic [PAYLOAD_BITS-1:0]       data_in,
  output logic                          done,
  output logic [PAYLOAD_BITS-1:0]       data_out,
  output logic [1:0]                    status,
  output logic [$clog2(CAPACITY+1)-1:0] length
);
  import pss_pkg::*;

  localparam int W  = PAYLOAD_BITS;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t state;
  state_t state_next;

  // captured command
  cmd_t              cmd_q;
  logic signed [7:0] pos_q;
  logic [W-1:0]      word_q;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  dec_t          dec;
  logic [IW-1:0] idx;
  cell_op_t      cell_op;

  logic [W-1:0] q  [CAPACITY];
  logic [W-1:0] rd [CAPACITY];
  logic [W-1:0] rd_word;

  logic accept;
  assign accept = start && !busy;

  // ---- control FSM ----
  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_EXEC:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // command capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      pos_q  <= position;
      word_q <= data_in;
    end
  end

  // ---- decode: resolve position, check range/full/empty ----
  pss_decode #(.CAPACITY(CAPACITY)) u_decode (
    .cmd      (cmd_q),
    .position (pos_q),
    .count    (count),
    .dec      (dec),
    .idx      (idx)
  );

  // cells only move in the exec cycle
  assign cell_op = (state == S_EXEC) ? dec.op : CELL_HOLD;

  // ---- cell chain: insert shifts toward the back, remove toward the front ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [W-1:0] left;
    logic [W-1:0] right;
    if (i == 0) begin : g_first
      assign left = word_q;
    end else begin : g_mid_l
      assign left = q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = q[i];
    end else begin : g_mid_r
      assign right = q[i+1];
    end
    pss_cell #(.W(W), .IW(IW), .IDX(i)) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .idx   (idx),
      .word  (word_q),
      .left  (left),
      .right (right),
      .q     (q[i]),
      .rd    (rd[i])
    );
  end

  // only the addressed cell drives a nonzero read word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd[i];
    end
  end

  // ---- length ----
  always_comb begin
    count_next = count;
    if (dec.grow) count_next = count + CW'(1);
    else if (dec.shrink) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (state == S_EXEC) count <= count_next;
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      data_out <= dec.rd ? rd_word : '0;
      status   <= dec.status;
      length   <= count_next;
    end
  end

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored length exceeds capacity");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an exec cycle");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (data_out == '0))
    else $error("failed transaction returned payload");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> (length == CW'(CAPACITY)))
    else $error("full status below capacity");

endmodule

>>> hw/rtl/pss_cell.sv
module pss_cell #(
  parameter int W   = 32,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pss_pkg::cell_op_t op,
  input  logic [IW-1:0]     idx,
  input  logic [W-1:0]      word,
  input  logic [W-1:0]      left,
  input  logic [W-1:0]      right,
  output logic [W-1:0]      q,
  output logic [W-1:0]      rd
);
  import pss_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic         at;
  logic         after;
  logic [W-1:0] q_next;

  assign at    = (idx == MY_IDX);
  assign after = (MY_IDX > idx);
  assign rd    = at ? q : '0;

  always_comb begin
    q_next = q;
    case (op)
      CELL_INSERT: begin
        if (at) q_next = word;
        else if (after) q_next = left;
      end
      CELL_REMOVE: begin
        if (at || after) q_next = right;
      end
      CELL_WRITE: begin
        if (at) q_next = word;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> hw/rtl/pss_decode.sv
module pss_decode #(
  parameter int CAPACITY = 64
) (
  input  pss_pkg::cmd_t                    cmd,
  input  logic signed [7:0]                position,
  input  logic [$clog2(CAPACITY+1)-1:0]    count,
  output pss_pkg::dec_t                    dec,
  output logic [$clog2(CAPACITY)-1:0]      idx
);
  import pss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW + 1 > 8) ? CW + 1 : 8) + 1;

  logic signed [PW-1:0] pos_s;
  logic signed [PW-1:0] len_s;
  logic signed [PW-1:0] p;
  logic                 full;
  logic                 empty;
  logic                 oor_get;
  logic                 oor_ins;
  logic [CW-1:0]        last;

  assign pos_s   = PW'(position);
  assign len_s   = $signed({{(PW-CW){1'b0}}, count});
  assign p       = (position < 0) ? pos_s + len_s : pos_s;
  assign full    = (count >= CW'(CAPACITY));
  assign empty   = (count == '0);
  assign oor_get = (p < 0) || (p >= len_s);
  assign oor_ins = (p < 0) || (p > len_s);
  assign last    = count - CW'(1);

  always_comb begin
    dec = '{status: ST_OK, op: CELL_HOLD, rd: 1'b0, grow: 1'b0, shrink: 1'b0};
    idx = p[IW-1:0];
    case (cmd)
      CMD_PUSH_FRONT: begin
        idx = '0;
        if (full) dec.status = ST_FULL;
        else begin
          dec.op   = CELL_INSERT;
          dec.grow = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        idx = count[IW-1:0];
        if (full) dec.status = ST_FULL;
        else begin
          dec.op   = CELL_INSERT;
          dec.grow = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        idx = '0;
        if (empty) dec.status = ST_EMPTY;
        else begin
          dec.op     = CELL_REMOVE;
          dec.rd     = 1'b1;
          dec.shrink = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        idx = last[IW-1:0];
        if (empty) dec.status = ST_EMPTY;
        else begin
          dec.op     = CELL_REMOVE;
          dec.rd     = 1'b1;
          dec.shrink = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (oor_ins) dec.status = ST_RANGE;
        else if (full) dec.status = ST_FULL;
        else begin
          dec.op   = CELL_INSERT;
          dec.grow = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) dec.status = ST_EMPTY;
        else if (oor_get) dec.status = ST_RANGE;
        else begin
          dec.op     = CELL_REMOVE;
          dec.rd     = 1'b1;
          dec.shrink = 1'b1;
        end
      end
      CMD_GET: begin
        if (oor_get) dec.status = ST_RANGE;
        else dec.rd = 1'b1;
      end
      CMD_SET: begin
        if (oor_get) dec.status = ST_RANGE;
        else dec.op = CELL_WRITE;
      end
      default: dec.status = ST_RANGE;
    endcase
  end

endmodule

>>> bench/positional_sequence_store_tb.sv
`timescale 1ns / 100ps

module positional_sequence_store_tb;
  import pss_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int LEN_BITS     = $clog2(CAPACITY + 1);

  // One command transaction as queued for the driver. A set hold flag makes
  // the driver sit idle until every outstanding result has come back.
  typedef struct {
    cmd_t                    op;
    logic signed [7:0]       pos;
    logic [PAYLOAD_BITS-1:0] word;
    bit                      hold;
  } store_op_t;

  // What the store should answer for one command.
  typedef struct {
    logic [PAYLOAD_BITS-1:0] word;
    status_t                 st;
    logic [LEN_BITS-1:0]     len;
  } store_reply_t;

  // Random traffic mixes: lean toward filling, toward draining, or neither.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [2:0]              cmd = CMD_PUSH_FRONT;
  logic signed [7:0]       position = '0;
  logic [PAYLOAD_BITS-1:0] data_in = '0;
  logic                    busy;
  logic                    done;
  logic [PAYLOAD_BITS-1:0] data_out;
  logic [1:0]              status;
  logic [LEN_BITS-1:0]     length;

  store_op_t    pending_ops[$];   // filled up front, drained by the driver
  store_reply_t replies_due[$];   // predicted replies, oldest first
  store_op_t    in_flight;        // command currently on the input ports

  // Shadow copy of the store contents, advanced at each accepted command
  logic [PAYLOAD_BITS-1:0] shadow_cells[CAPACITY];
  int                      shadow_count = 0;

  int gen_len = 0;     // length as seen by the stimulus generator
  int burst_left = 0;
  int gap_left = 0;
  int mismatches = 0;

  always #5 clk = ~clk;

  positional_sequence_store #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .position(position),
    .data_in (data_in),
    .done    (done),
    .data_out(data_out),
    .status  (status),
    .length  (length)
  );

  // ---------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow store and queues
  // the reply. Negative positions resolve once against the current length;
  // anything that fails leaves the shadow store untouched.
  // ---------------------------------------------------------------------
  task automatic predict_store_op(input store_op_t r);
    int                      n;
    int                      p;
    int                      idx;
    int                      i;
    bit                      grow;
    bit                      shrink;
    store_reply_t            e;
    n      = shadow_count;
    p      = (r.pos < 0) ? int'(r.pos) + n : int'(r.pos);
    e.word = '0;
    e.st   = ST_OK;
    grow   = 1'b0;
    shrink = 1'b0;
    idx    = 0;
    case (r.op)
      CMD_PUSH_FRONT: begin
        if (n >= CAPACITY) e.st = ST_FULL;
        else begin grow = 1'b1; idx = 0; end
      end
      CMD_PUSH_BACK: begin
        if (n >= CAPACITY) e.st = ST_FULL;
        else begin grow = 1'b1; idx = n; end
      end
      CMD_POP_FRONT: begin
        if (n == 0) e.st = ST_EMPTY;
        else begin shrink = 1'b1; idx = 0; end
      end
      CMD_POP_BACK: begin
        if (n == 0) e.st = ST_EMPTY;
        else begin shrink = 1'b1; idx = n - 1; end
      end
      CMD_INSERT: begin
        // insert at either end is just a push, full status included
        if (p < 0 || p > n) e.st = ST_RANGE;
        else if (n >= CAPACITY) e.st = ST_FULL;
        else begin grow = 1'b1; idx = p; end
      end
      CMD_REMOVE: begin
        if (n == 0) e.st = ST_EMPTY;
        else if (p < 0 || p >= n) e.st = ST_RANGE;
        else begin shrink = 1'b1; idx = p; end
      end
      CMD_GET: begin
        if (p < 0 || p >= n) e.st = ST_RANGE;
        else e.word = shadow_cells[p];
      end
      default: begin
        if (p < 0 || p >= n) e.st = ST_RANGE;
        else shadow_cells[p] = r.word;
      end
    endcase
    if (grow) begin
      for (i = n; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
      shadow_cells[idx] = r.word;
      shadow_count++;
    end
    if (shrink) begin
      e.word = shadow_cells[idx];
      for (i = idx; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i+1];
      shadow_count--;
    end
    e.len = LEN_BITS'(shadow_count);
    replies_due.push_back(e);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers. The generator tracks the length on its own (it only
  // depends on command, position and length, never on data) so positions
  // can be aimed at the live contents.
  // ---------------------------------------------------------------------
  task automatic queue_op(input cmd_t op, input int pos, input logic [31:0] word,
                          input bit hold);
    store_op_t r;
    int        p;
    r.op   = op;
    r.pos  = pos[7:0];
    r.word = word;
    r.hold = hold;
    p = (r.pos < 0) ? int'(r.pos) + gen_len : int'(r.pos);
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_len < CAPACITY) gen_len++;
      CMD_POP_FRONT, CMD_POP_BACK:   if (gen_len > 0) gen_len--;
      CMD_INSERT: if (p >= 0 && p <= gen_len && gen_len < CAPACITY) gen_len++;
      CMD_REMOVE: if (gen_len > 0 && p >= 0 && p < gen_len) gen_len--;
      default: ;
    endcase
    pending_ops.push_back(r);
  endtask

  // Mostly a live index (either sign), some edge positions at or just outside
  // the ends, and some raw 8-bit noise.
  function automatic int pick_position(input cmd_t op);
    int r;
    int top;
    int t;
    r   = $urandom_range(0, 99);
    top = (op == CMD_INSERT) ? gen_len : gen_len - 1;
    if (r < 75 && top >= 0) begin
      t = $urandom_range(0, top);
      if ($urandom_range(0, 1) && t - gen_len < 0) return t - gen_len;
      return t;
    end
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return gen_len;
        1:       return gen_len + 1;
        2:       return -gen_len - 1;
        default: return -gen_len;
      endcase
    end
    return int'($signed(8'($urandom_range(0, 255))));
  endfunction

  function automatic cmd_t pick_command(input op_mix_t mix);
    cmd_t adds[3]   = '{CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT};
    cmd_t takes[3]  = '{CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE};
    cmd_t access[2] = '{CMD_GET, CMD_SET};
    int   r;
    int   add_pct;
    int   take_pct;
    r        = $urandom_range(0, 99);
    add_pct  = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
    take_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 60 : 35;
    if (r < add_pct) return adds[$urandom_range(0, 2)];
    if (r < add_pct + take_pct) return takes[$urandom_range(0, 2)];
    return access[$urandom_range(0, 1)];
  endfunction

  // ---------------------------------------------------------------------
  // Driver: a command is taken at an edge with start high and busy low.
  // On that edge the taken command is predicted, then the next one (or an
  // idle cycle) is put on the ports. Traffic comes in bursts of random
  // length with random gaps; some gaps are zero so bursts run back to back.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : driver
    store_op_t nxt;
    bit        took;
    bit        drive;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) predict_store_op(in_flight);
      if (!start || took) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].hold && replies_due.size() != 0)) begin
          nxt   = pending_ops.pop_front();
          drive = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end
        start <= drive;
        if (drive) begin
          in_flight = nxt;
          cmd      <= nxt.op;
          position <= nxt.pos;
          data_in  <= nxt.word;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: done marks a one-cycle reply; no back-pressure exists, so each
  // strobe is checked against the oldest prediction right away.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    store_reply_t e;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        $error("reply with no command outstanding: data_out %h status %0d length %0d",
               data_out, status, length);
        mismatches++;
      end else begin
        e = replies_due.pop_front();
        if (data_out !== e.word) begin
          $error("data_out: expected %h, actual %h", e.word, data_out);
          mismatches++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status);
          mismatches++;
        end
        if (length !== e.len) begin
          $error("length: expected %0d, actual %0d", e.len, length);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    op_mix_t mix;
    int      k;
    cmd_t    op;

    // empty store: every removal is empty, every access out of range
    queue_op(CMD_POP_FRONT, 0, 32'h0, 1'b0);
    queue_op(CMD_POP_BACK, 0, 32'h0, 1'b0);
    queue_op(CMD_REMOVE, 0, 32'h0, 1'b0);
    queue_op(CMD_GET, 0, 32'h0, 1'b0);
    queue_op(CMD_SET, -1, 32'h1234_5678, 1'b0);
    queue_op(CMD_INSERT, 1, 32'h5555_5555, 1'b0);
    // insert at front of an empty store acts as a push
    queue_op(CMD_INSERT, 0, 32'hA5A5_A5A5, 1'b0);
    queue_op(CMD_PUSH_BACK, 0, 32'hFFFF_FFFF, 1'b0);
    queue_op(CMD_PUSH_FRONT, 0, 32'h0000_0000, 1'b0);
    queue_op(CMD_INSERT, 3, 32'h8000_0001, 1'b0);    // at the length: push back
    queue_op(CMD_INSERT, -1, 32'h0F0F_F0F0, 1'b0);   // middle, counted from end
    queue_op(CMD_INSERT, -128, 32'hDEAD_BEEF, 1'b0); // far below
    queue_op(CMD_INSERT, 127, 32'hDEAD_BEEF, 1'b0);  // far above
    queue_op(CMD_GET, -1, 32'h0, 1'b0);
    queue_op(CMD_GET, 5, 32'h0, 1'b0);
    queue_op(CMD_GET, -5, 32'h0, 1'b0);              // wraps exactly to front
    queue_op(CMD_GET, -6, 32'h0, 1'b0);              // still negative: range
    queue_op(CMD_SET, 2, 32'h7FFF_FFFE, 1'b0);
    queue_op(CMD_REMOVE, 5, 32'h0, 1'b0);            // at the length: range
    queue_op(CMD_REMOVE, 4, 32'h0, 1'b0);            // last element
    queue_op(CMD_REMOVE, -1, 32'h0, 1'b0);
    queue_op(CMD_REMOVE, 0, 32'h0, 1'b0);
    queue_op(CMD_POP_BACK, 0, 32'h0, 1'b0);
    queue_op(CMD_POP_FRONT, 0, 32'h0, 1'b0);
    queue_op(CMD_POP_BACK, 0, 32'h0, 1'b0);

    // fill to capacity with random words, mostly at random live positions
    while (gen_len < CAPACITY) begin
      op = ($urandom_range(0, 1)) ? CMD_INSERT : CMD_PUSH_BACK;
      queue_op(op, pick_position(op), $urandom(), 1'b0);
    end
    // full store cases, the first one after a pause until all replies are in
    queue_op(CMD_PUSH_FRONT, 0, $urandom(), 1'b1);
    queue_op(CMD_PUSH_BACK, 0, $urandom(), 1'b0);
    queue_op(CMD_INSERT, 30, $urandom(), 1'b0);
    queue_op(CMD_INSERT, 0, $urandom(), 1'b0);
    queue_op(CMD_INSERT, CAPACITY, $urandom(), 1'b0);
    queue_op(CMD_INSERT, -1, $urandom(), 1'b0);
    queue_op(CMD_INSERT, CAPACITY + 1, $urandom(), 1'b0);
    queue_op(CMD_INSERT, -CAPACITY - 1, $urandom(), 1'b0);
    queue_op(CMD_GET, -CAPACITY, 32'h0, 1'b0);
    queue_op(CMD_SET, CAPACITY - 1, $urandom(), 1'b0);
    queue_op(CMD_REMOVE, CAPACITY, 32'h0, 1'b0);

    // random traffic in segments of one mix; a drain pause every so often
    mix = MIX_EVEN;
    for (k = 0; k < 1500; k++) begin
      if (k % 120 == 0) mix = op_mix_t'($urandom_range(0, 2));
      op = pick_command(mix);
      queue_op(op, pick_position(op), $urandom(), (k % 250) == 249);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wait for the last command to go out and its reply to come back
    @(posedge clk);
    while (pending_ops.size() != 0 || start || replies_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
